[rtl/core/mhnn_pkg.sv]
package mhnn_pkg;

  // Field widths fixed by the interface
  localparam int IDX_W          = 10;
  localparam int DIST_W         = 9;
  localparam int DBSZ_W         = 11;
  localparam int OP_W           = 2;
  localparam int WORD_BITS      = 64;
  localparam int MASK_IDX_W     = 4;
  localparam int MAX_MASK_WORDS = 16;
  localparam int LANE_CNT_W     = 7;

  // Parameter defaults
  localparam int DB_DEPTH_DEF  = 1024;
  localparam int DESC_BITS_DEF = 256;

  localparam logic [DBSZ_W-1:0] DB_SIZE_RESET = 11'd1024;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_MASK  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  // Candidate entering the distance unit
  typedef struct packed {
    logic valid;
    logic excluded;
  } cand_ctl_t;

  // 64-bit population count as an adder tree
  function automatic logic [LANE_CNT_W-1:0] popcount64(input logic [WORD_BITS-1:0] x);
    logic [1:0] l1 [32];
    logic [2:0] l2 [16];
    logic [3:0] l3 [8];
    logic [4:0] l4 [4];
    logic [5:0] l5 [2];
    for (int i = 0; i < 32; i++) l1[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
    for (int i = 0; i < 16; i++) l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    for (int i = 0; i < 8; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    for (int i = 0; i < 4; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    for (int i = 0; i < 2; i++)  l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
    return {1'b0, l5[0]} + {1'b0, l5[1]};
  endfunction

endpackage

[rtl/core/masked_hamming_nearest_neighbour_unit.sv]
// Brute-force Hamming nearest-neighbour matcher over a store of DB_DEPTH binary
// descriptors of DESC_BITS bits. Drive start with an operation when busy is low:
// a load writes one descriptor into slot in_entry_index, a mask write replaces one
// 64-bit word of the exclusion bitmap (bit set = entry skipped), and a query scans
// entries 0 .. min(db_size, DB_DEPTH)-1. Loads and mask writes never raise busy.
// A query holds busy until its result has been shown: the scan reads one store
// entry per cycle through the single descriptor memory read port, then the
// drain state empties the popcount and compare stages and the done state
// shows the result. The result appears for exactly one cycle with
// out_valid high; there is no way to stall it, so capture it in that cycle.
// When no entry is eligible the result is index 0, distance DESC_BITS and
// out_all_masked high. The exclusion bitmap clears at reset; descriptor slots
// hold garbage until loaded, so only query over loaded slots. Write db_size via
// cfg_we only while busy is low.
module masked_hamming_nearest_neighbour_unit
  import mhnn_pkg::*;
#(
  parameter int DB_DEPTH  = DB_DEPTH_DEF,
  parameter int DESC_BITS = DESC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [IDX_W-1:0]      in_entry_index,
  input  logic [WORD_BITS-1:0]  in_desc_word_0,
  input  logic [WORD_BITS-1:0]  in_desc_word_1,
  input  logic [WORD_BITS-1:0]  in_desc_word_2,
  input  logic [WORD_BITS-1:0]  in_desc_word_3,
  input  logic [MASK_IDX_W-1:0] in_mask_word_index,
  input  logic [WORD_BITS-1:0]  in_mask_bits,
  // result channel
  output logic                  out_valid,
  output logic [IDX_W-1:0]      out_best_index,
  output logic [DIST_W-1:0]     out_best_distance,
  output logic                  out_all_masked,
  // configuration
  input  logic                  cfg_we,
  input  logic [DBSZ_W-1:0]     cfg_wdata
);

  localparam int AW = $clog2(DB_DEPTH);

  state_t               state_r, state_nxt;
  logic [DBSZ_W-1:0]    db_size_r;
  logic [AW-1:0]        ent_r, ent_nxt;
  logic [AW-1:0]        last_r, last_nxt;
  logic                 drain_r, drain_nxt;
  logic                 cand_valid_r;
  logic [AW-1:0]        cand_idx_r;

  logic                 accept;
  logic                 load_we;
  logic                 mask_we;
  logic                 query_go;
  logic [31:0]          limit32;
  logic [DESC_BITS-1:0] desc_in;
  logic [DESC_BITS-1:0] rd_data;
  logic                 rd_excluded;
  cand_ctl_t            cand;
  logic [AW-1:0]        best_idx;
  logic [DIST_W-1:0]    best_dist;
  logic                 found;

  // Handshake decode: a transfer happens on start while not busy
  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign load_we  = accept && (in_operation == OP_LOAD)
                    && (32'(in_entry_index) < 32'(DB_DEPTH));
  assign mask_we  = accept && (in_operation == OP_MASK);
  assign query_go = accept && (in_operation == OP_QUERY);

  // Bits above DESC_BITS are dropped on both load and query
  assign desc_in = DESC_BITS'({in_desc_word_3, in_desc_word_2,
                               in_desc_word_1, in_desc_word_0});

  // Searched entries: db_size saturated to the store depth
  assign limit32 = (32'(db_size_r) > 32'(DB_DEPTH)) ? 32'(DB_DEPTH) : 32'(db_size_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_size_r <= DB_SIZE_RESET;
    end else if (cfg_we) begin
      db_size_r <= cfg_wdata;
    end
  end

  // Sequencer: walk the entry counter, then let the pipeline drain
  always_comb begin
    state_nxt = state_r;
    ent_nxt   = ent_r;
    last_nxt  = last_r;
    drain_nxt = drain_r;
    unique case (state_r)
      ST_IDLE: begin
        if (query_go) begin
          ent_nxt   = '0;
          last_nxt  = AW'(limit32 - 32'd1);
          drain_nxt = 1'b0;
          state_nxt = (limit32 == 32'd0) ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        ent_nxt = ent_r + AW'(1);
        if (ent_r == last_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ent_r        <= '0;
      last_r       <= '0;
      drain_r      <= 1'b0;
      cand_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ent_r        <= ent_nxt;
      last_r       <= last_nxt;
      drain_r      <= drain_nxt;
      cand_valid_r <= (state_r == ST_SCAN);
    end
  end

  // Tag travels alongside the registered store read
  always_ff @(posedge clk) begin
    cand_idx_r <= ent_r;
  end

  mhnn_desc_store #(
    .DB_DEPTH  (DB_DEPTH),
    .DESC_BITS (DESC_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (load_we),
    .wr_addr (AW'(in_entry_index)),
    .wr_data (desc_in),
    .rd_addr (ent_r),
    .rd_data (rd_data)
  );

  mhnn_excl_map #(
    .DB_DEPTH (DB_DEPTH)
  ) u_map (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (mask_we),
    .wr_word     (in_mask_word_index),
    .wr_bits     (in_mask_bits),
    .rd_entry    (ent_r),
    .rd_excluded (rd_excluded)
  );

  assign cand.valid    = cand_valid_r;
  assign cand.excluded = rd_excluded;

  mhnn_dist_unit #(
    .DB_DEPTH  (DB_DEPTH),
    .DESC_BITS (DESC_BITS)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (query_go),
    .query     (desc_in),
    .cand      (cand),
    .cand_idx  (cand_idx_r),
    .cand_data (rd_data),
    .best_idx  (best_idx),
    .best_dist (best_dist),
    .found     (found)
  );

  // Result transfer: one cycle in DONE, straight from the best registers
  assign out_valid         = (state_r == ST_DONE);
  assign out_best_index    = IDX_W'(best_idx);
  assign out_best_distance = best_dist;
  assign out_all_masked    = !found;

  // A query transfer always raises busy on the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_operation == OP_QUERY)) |=> busy)
    else $error("query transfer did not start a scan");

  // Load and mask transfers never produce a result or stall the port
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_operation != OP_QUERY)) |=> (!busy && !out_valid))
    else $error("write transfer affected busy or result");

  // The result is shown once and releases the port
  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!busy && !out_valid))
    else $error("result not followed by idle");

  // An empty search reports the fallback answer
  a_all_masked_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_all_masked) |->
      ((out_best_distance == DIST_W'(DESC_BITS)) && (out_best_index == '0)))
    else $error("all-masked result has wrong index or distance");

endmodule

[rtl/core/mhnn_desc_store.sv]
module mhnn_desc_store
  import mhnn_pkg::*;
#(
  parameter int DB_DEPTH  = DB_DEPTH_DEF,
  parameter int DESC_BITS = DESC_BITS_DEF,
  localparam int AW = $clog2(DB_DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [DESC_BITS-1:0] wr_data,
  input  logic [AW-1:0]        rd_addr,
  output logic [DESC_BITS-1:0] rd_data
);

  logic [DESC_BITS-1:0] mem [DB_DEPTH];
  logic [DESC_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/mhnn_excl_map.sv]
module mhnn_excl_map
  import mhnn_pkg::*;
#(
  parameter int DB_DEPTH = DB_DEPTH_DEF,
  localparam int AW       = $clog2(DB_DEPTH),
  localparam int NEED_W   = (DB_DEPTH + WORD_BITS - 1) / WORD_BITS,
  localparam int BM_WORDS = (NEED_W < MAX_MASK_WORDS) ? NEED_W : MAX_MASK_WORDS,
  localparam int BM_AW    = (BM_WORDS > 1) ? $clog2(BM_WORDS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [MASK_IDX_W-1:0] wr_word,
  input  logic [WORD_BITS-1:0]  wr_bits,
  input  logic [AW-1:0]         rd_entry,
  output logic                  rd_excluded
);

  logic [WORD_BITS-1:0] map_r [BM_WORDS];
  logic                 excl_r;
  logic [31:0]          rd_word32;
  logic                 rd_in_map;
  logic [BM_AW-1:0]     rd_word;
  logic [5:0]           rd_bit;

  // Drop writes to words the store does not need
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BM_WORDS; i++) map_r[i] <= '0;
    end else if (wr_en && (32'(wr_word) < 32'(BM_WORDS))) begin
      map_r[BM_AW'(wr_word)] <= wr_bits;
    end
  end

  always_comb begin
    rd_word32 = 32'(rd_entry) >> 6;
    rd_in_map = rd_word32 < 32'(BM_WORDS);
    rd_word   = BM_AW'(rd_word32);
    rd_bit    = 6'(32'(rd_entry) & 32'd63);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      excl_r <= 1'b0;
    end else begin
      excl_r <= rd_in_map && map_r[rd_word][rd_bit];
    end
  end

  assign rd_excluded = excl_r;

endmodule

[rtl/core/mhnn_dist_unit.sv]
module mhnn_dist_unit
  import mhnn_pkg::*;
#(
  parameter int DB_DEPTH  = DB_DEPTH_DEF,
  parameter int DESC_BITS = DESC_BITS_DEF,
  localparam int AW    = $clog2(DB_DEPTH),
  localparam int LANES = (DESC_BITS + WORD_BITS - 1) / WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clear,
  input  logic [DESC_BITS-1:0] query,
  input  cand_ctl_t            cand,
  input  logic [AW-1:0]        cand_idx,
  input  logic [DESC_BITS-1:0] cand_data,
  output logic [AW-1:0]        best_idx,
  output logic [DIST_W-1:0]    best_dist,
  output logic                 found
);

  logic [DESC_BITS-1:0]       query_r;
  logic [LANES*WORD_BITS-1:0] diff_pad;
  logic [LANE_CNT_W-1:0]      lane_cnt_r [LANES];
  logic                       s1_valid_r;
  logic [AW-1:0]              s1_idx_r;
  logic [DIST_W-1:0]          cand_dist;
  logic [AW-1:0]              best_idx_r;
  logic [DIST_W-1:0]          best_dist_r;
  logic                       found_r;

  always_ff @(posedge clk) begin
    if (clear) begin
      query_r <= query;
    end
  end

  // Stage 1: XOR and per-lane popcount
  assign diff_pad = (LANES*WORD_BITS)'(query_r ^ cand_data);

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      lane_cnt_r[l] <= popcount64(diff_pad[l*WORD_BITS +: WORD_BITS]);
    end
    s1_idx_r <= cand_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cand.valid && !cand.excluded;
    end
  end

  // Stage 2: sum lanes, compare and keep the first strictly better entry
  always_comb begin
    cand_dist = '0;
    for (int l = 0; l < LANES; l++) begin
      cand_dist = cand_dist + DIST_W'(lane_cnt_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      best_idx_r  <= '0;
      best_dist_r <= DIST_W'(DESC_BITS);
    end else if (clear) begin
      found_r     <= 1'b0;
      best_idx_r  <= '0;
      best_dist_r <= DIST_W'(DESC_BITS);
    end else if (s1_valid_r && (!found_r || (cand_dist < best_dist_r))) begin
      found_r     <= 1'b1;
      best_idx_r  <= s1_idx_r;
      best_dist_r <= cand_dist;
    end
  end

  assign best_idx  = best_idx_r;
  assign best_dist = best_dist_r;
  assign found     = found_r;

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
module testbench;
  import mhnn_pkg::*;

  localparam int DESC_W = DESC_BITS_DEF;
  localparam int ENTRIES = DB_DEPTH_DEF;
  // Slots loaded up front; every searched window stays inside them
  localparam int FILL_SLOTS = 300;
  // Operation code the block must ignore
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  // Allow several full-store scans to pass without any transfer
  localparam int QUIET_LIMIT = 6000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_GAP = 40;
  localparam int SEGMENTS = 12;

  typedef struct {
    logic [OP_W-1:0]       op;
    logic [IDX_W-1:0]      entry;
    logic [DESC_W-1:0]     desc;
    logic [MASK_IDX_W-1:0] mword;
    logic [WORD_BITS-1:0]  mbits;
  } command_t;

  typedef struct {
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] distance;
    logic              all_masked;
  } match_t;

  // Mirror of the descriptor store, exclusion bitmap and store size; keeps the
  // nearest matches still owed by the block in transfer order.
  class match_scoreboard;
    logic [DESC_W-1:0]    store [ENTRIES];
    logic [WORD_BITS-1:0] exclusion [MAX_MASK_WORDS];
    logic [DBSZ_W-1:0]    db_size;
    match_t               expected_matches [$];
    int unsigned          errors;
    int unsigned          loads;
    int unsigned          mask_writes;
    int unsigned          queries;
    int unsigned          fully_masked;

    function new();
      foreach (store[i]) store[i] = '0;
      foreach (exclusion[i]) exclusion[i] = '0;
      db_size = DB_SIZE_RESET;
      errors = 0;
      loads = 0;
      mask_writes = 0;
      queries = 0;
      fully_masked = 0;
    endfunction

    function int unsigned scan_limit();
      return (db_size > ENTRIES) ? ENTRIES : int'(db_size);
    endfunction

    // Lowest Hamming distance over eligible entries; first index wins ties
    function match_t nearest_entry(logic [DESC_W-1:0] query);
      match_t      best;
      int unsigned ham_dist;
      int unsigned e;
      best.index = '0;
      best.distance = DIST_W'(DESC_W);
      best.all_masked = 1'b1;
      for (e = 0; e < scan_limit(); e++) begin
        if (exclusion[e / 64][e % 64]) continue;
        ham_dist = $countones(query ^ store[e]);
        if (best.all_masked || ham_dist < best.distance) begin
          best.all_masked = 1'b0;
          best.distance = DIST_W'(ham_dist);
          best.index = IDX_W'(e);
        end
      end
      return best;
    endfunction

    function void note_command(command_t c);
      case (c.op)
        OP_LOAD: begin
          store[c.entry] = c.desc;
          loads++;
        end
        OP_MASK: begin
          exclusion[c.mword] = c.mbits;
          mask_writes++;
        end
        OP_QUERY: expected_matches.insert(expected_matches.size(), nearest_entry(c.desc));
        default: ;
      endcase
    endfunction

    function void check_result(logic [IDX_W-1:0] index, logic [DIST_W-1:0] distance,
                               logic all_masked);
      match_t want;
      if (expected_matches.size() == 0) begin
        $error("result transfer with no query outstanding: index %0d distance %0d",
               index, distance);
        errors++;
        return;
      end
      want = expected_matches.pop_front();
      queries++;
      if (want.all_masked) fully_masked++;
      if (index !== want.index) begin
        $error("best_index mismatch: expected %0d, actual %0d", want.index, index);
        errors++;
      end
      if (distance !== want.distance) begin
        $error("best_distance mismatch: expected %0d, actual %0d", want.distance, distance);
        errors++;
      end
      if (all_masked !== want.all_masked) begin
        $error("all_masked mismatch: expected %0d, actual %0d", want.all_masked, all_masked);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [OP_W-1:0]       in_operation = OP_LOAD;
  logic [IDX_W-1:0]      in_entry_index = '0;
  logic [WORD_BITS-1:0]  in_desc_word_0 = '0;
  logic [WORD_BITS-1:0]  in_desc_word_1 = '0;
  logic [WORD_BITS-1:0]  in_desc_word_2 = '0;
  logic [WORD_BITS-1:0]  in_desc_word_3 = '0;
  logic [MASK_IDX_W-1:0] in_mask_word_index = '0;
  logic [WORD_BITS-1:0]  in_mask_bits = '0;
  logic                  out_valid;
  logic [IDX_W-1:0]      out_best_index;
  logic [DIST_W-1:0]     out_best_distance;
  logic                  out_all_masked;
  logic                  cfg_we = 1'b0;
  logic [DBSZ_W-1:0]     cfg_wdata = '0;

  match_scoreboard sb;
  int unsigned     quiet_cycles = 0;
  int unsigned     settings_used = 0;

  // Store sizes per random segment: extremes and word boundaries inside the loaded slots
  logic [DBSZ_W-1:0] seg_sizes [SEGMENTS] = '{11'd1, 11'd64, 11'd300, 11'd0, 11'd37,
                                              11'd257, 11'd130, 11'd2, 11'd65, 11'd256,
                                              11'd200, 11'd13};
  int unsigned idle_rates [3] = '{0, 67, 26};

  masked_hamming_nearest_neighbour_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_entry_index    (in_entry_index),
    .in_desc_word_0    (in_desc_word_0),
    .in_desc_word_1    (in_desc_word_1),
    .in_desc_word_2    (in_desc_word_2),
    .in_desc_word_3    (in_desc_word_3),
    .in_mask_word_index(in_mask_word_index),
    .in_mask_bits      (in_mask_bits),
    .out_valid         (out_valid),
    .out_best_index    (out_best_index),
    .out_best_distance (out_best_distance),
    .out_all_masked    (out_all_masked),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sample the result port mid-cycle: inputs only change at the rising edge, so
  // what is seen here is exactly what the next edge transfers.
  always @(negedge clk) begin
    if (rst_n && out_valid === 1'b1)
      sb.check_result(out_best_index, out_best_distance, out_all_masked);
  end

  // Watchdog: count cycles without a command or result transfer
  always @(negedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d queries still owed",
                 quiet_cycles, sb.expected_matches.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic logic [DESC_W-1:0] random_desc();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [DESC_W-1:0] flip_bits(logic [DESC_W-1:0] d, int unsigned n);
    int unsigned b;
    repeat (n) begin
      b = $urandom_range(DESC_W - 1);
      d[b] = ~d[b];
    end
    return d;
  endfunction

  // Exclusion words from empty to full, with sparse and dense mixes between
  function automatic logic [WORD_BITS-1:0] mask_pattern();
    case ($urandom_range(6))
      0:       return '0;
      1:       return '1;
      2, 3:    return {$urandom, $urandom};
      4:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom} | {$urandom, $urandom};
    endcase
  endfunction

  // Every field random; the operation-specific ones get overridden by the caller
  function automatic command_t random_fields();
    command_t c;
    c.op = OP_W'($urandom_range(3));
    c.entry = IDX_W'($urandom);
    c.desc = random_desc();
    c.mword = MASK_IDX_W'($urandom);
    c.mbits = {$urandom, $urandom};
    return c;
  endfunction

  function automatic command_t load_cmd(int unsigned entry, logic [DESC_W-1:0] desc);
    command_t c;
    c = random_fields();
    c.op = OP_LOAD;
    c.entry = IDX_W'(entry);
    c.desc = desc;
    return c;
  endfunction

  function automatic command_t mask_cmd(int unsigned word, logic [WORD_BITS-1:0] bits);
    command_t c;
    c = random_fields();
    c.op = OP_MASK;
    c.mword = MASK_IDX_W'(word);
    c.mbits = bits;
    return c;
  endfunction

  function automatic command_t query_cmd(logic [DESC_W-1:0] desc);
    command_t c;
    c = random_fields();
    c.op = OP_QUERY;
    c.desc = desc;
    return c;
  endfunction

  // Pick a slot inside the searched window, or anywhere when the window is empty
  function automatic int unsigned pick_entry(int unsigned lim);
    return (lim != 0) ? $urandom_range(lim - 1) : $urandom_range(ENTRIES - 1);
  endfunction

  // Bias traffic toward the searched window: near-copies of stored entries give
  // small distances and ties, masks mostly hit words that the scan covers.
  function automatic command_t random_command();
    command_t    c;
    int unsigned lim;
    int unsigned pick;
    c = random_fields();
    lim = sb.scan_limit();
    pick = $urandom_range(99);
    if (pick < 3) begin
      c.op = OP_RESERVED;
    end else if (pick < 40) begin
      c.op = OP_LOAD;
      if (lim != 0 && $urandom_range(9) < 7) c.entry = IDX_W'($urandom_range(lim - 1));
      if ($urandom_range(9) < 4)
        c.desc = flip_bits(sb.store[pick_entry(lim)], $urandom_range(3));
    end else if (pick < 57) begin
      c.op = OP_MASK;
      if (lim != 0 && $urandom_range(3) != 0)
        c.mword = MASK_IDX_W'($urandom_range((lim - 1) / 64));
      c.mbits = mask_pattern();
    end else begin
      c.op = OP_QUERY;
      pick = $urandom_range(9);
      if (pick < 6)
        c.desc = flip_bits(sb.store[pick_entry(lim)], $urandom_range(20));
      else if (pick < 7)
        c.desc = sb.store[pick_entry(lim)];
      else if (pick < 8)
        c.desc = $urandom_range(1) ? '1 : '0;
    end
    return c;
  endfunction

  function automatic int unsigned idle_gap(int unsigned pct);
    int unsigned g;
    g = 0;
    while (g < MAX_GAP && $urandom_range(99) < pct) g++;
    return g;
  endfunction

  // Hold the command until the block takes it. Enter and leave at a rising
  // edge; start stays high on return so back-to-back commands need no toggle.
  task automatic issue(input command_t c, input int unsigned gap);
    bit taken;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= c.op;
    in_entry_index <= c.entry;
    in_desc_word_0 <= c.desc[63:0];
    in_desc_word_1 <= c.desc[127:64];
    in_desc_word_2 <= c.desc[191:128];
    in_desc_word_3 <= c.desc[255:192];
    in_mask_word_index <= c.mword;
    in_mask_bits <= c.mbits;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = (busy === 1'b0);
      if (taken) sb.note_command(c);
      @(posedge clk);
    end
  endtask

  // Drop start and wait until every owed result has come and the block is idle
  task automatic wait_for_results();
    start <= 1'b0;
    do @(negedge clk); while (sb.expected_matches.size() != 0 || busy !== 1'b0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_db_size(input logic [DBSZ_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.db_size = value;
    settings_used++;
  endtask

  initial begin
    command_t    c;
    int unsigned seg;
    int unsigned n;
    int unsigned quota;
    int unsigned gap;
    int unsigned burst;
    int unsigned idle_pct;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the low slots once; no scan ever reaches past them
    for (int unsigned i = 0; i < FILL_SLOTS; i++) issue(load_cmd(i, random_desc()), 0);
    wait_for_results();
    write_db_size(11'(FILL_SLOTS));

    // Directed: index and pattern extremes, ties, exclusion
    issue(query_cmd(sb.store[FILL_SLOTS - 1]), 0);
    issue(load_cmd(0, '0), 0);
    issue(load_cmd(FILL_SLOTS - 1, '1), 1);
    issue(query_cmd('0), 0);
    issue(query_cmd('1), 2);
    issue(load_cmd(200, '0), 0);          // tie with slot 0: lower index wins
    issue(query_cmd('0), 0);
    issue(mask_cmd(0, '1), 0);            // exclude slots 0..63 so slot 200 wins
    issue(query_cmd('0), 0);
    issue(mask_cmd(3, 64'h1 << 8), 0);    // now exclude slot 200 as well
    issue(query_cmd('0), 3);
    issue(mask_cmd(15, 64'h8000_0000_0000_0000), 0);
    issue(query_cmd('1), 0);
    c = random_fields();
    c.op = OP_RESERVED;                   // ignored: no state change, no result
    issue(c, 0);
    issue(query_cmd('1), 0);
    issue(mask_cmd(3, '0), 0);
    issue(mask_cmd(15, '0), 0);
    // Window fully covered by an all-ones mask word
    wait_for_results();
    write_db_size(11'd64);
    issue(query_cmd(random_desc()), 0);
    // Empty window
    wait_for_results();
    write_db_size(11'd0);
    issue(query_cmd(random_desc()), 0);
    // Whole loaded window with its first word still excluded
    wait_for_results();
    write_db_size(11'(FILL_SLOTS));
    issue(query_cmd('0), 0);
    issue(mask_cmd(0, '0), 0);
    // Single entry at the largest possible distance, still eligible
    wait_for_results();
    write_db_size(11'd1);
    issue(query_cmd('1), 0);

    // Random segments: new store size and sender idle rate per segment, with
    // zero-gap bursts mixed in and an occasional pause until the block drains
    for (seg = 0; seg < SEGMENTS; seg++) begin
      wait_for_results();
      write_db_size(seg_sizes[seg]);
      idle_pct = idle_rates[seg % 3];
      quota = (seg_sizes[seg] >= 200) ? 14 : 25;
      n = 0;
      burst = 0;
      while (n < quota) begin
        c = random_command();
        if (burst == 0 && $urandom_range(9) == 0) burst = $urandom_range(12, 4);
        if (burst != 0) begin
          gap = 0;
          burst--;
        end else begin
          gap = idle_gap(idle_pct);
        end
        if ($urandom_range(99) < 2) wait_for_results();
        issue(c, gap);
        if (c.op != OP_RESERVED) n++;
      end
    end

    wait_for_results();
    $display("Covered %0d descriptor loads, %0d mask-word writes and %0d queries",
             sb.loads, sb.mask_writes, sb.queries);
    $display("(%0d fully excluded) over %0d store-size settings and idle rates of 0, 26, 67%%",
             sb.fully_masked, settings_used);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/mhnn_pkg.sv
rtl/core/mhnn_desc_store.sv
rtl/core/mhnn_excl_map.sv
rtl/core/mhnn_dist_unit.sv
rtl/core/masked_hamming_nearest_neighbour_unit.sv
bench/testbench.sv
